### src/skeq_pkg.sv
// shared types, constants and the scan-code lookup for the key event queue
`default_nettype none

package skeq_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH = 32;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

  // channel widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  // input beat kinds
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  // scan-code set 1 prefixes and extended arrow codes
  localparam logic [7:0] PREFIX_EXT   = 8'hE0;
  localparam logic [7:0] PREFIX_PAUSE = 8'hE1;
  localparam logic [6:0] CODE_UP      = 7'h48;
  localparam logic [6:0] CODE_DOWN    = 7'h50;
  localparam logic [6:0] CODE_LEFT    = 7'h4B;
  localparam logic [6:0] CODE_RIGHT   = 7'h4D;

  // arrow characters
  localparam logic [6:0] CHAR_UP    = 7'd1;
  localparam logic [6:0] CHAR_DOWN  = 7'd2;
  localparam logic [6:0] CHAR_LEFT  = 7'd3;
  localparam logic [6:0] CHAR_RIGHT = 7'd4;

  // one stored key event
  typedef struct packed {
    logic [6:0] ch;
    logic       pressed;
    logic [6:0] code;
  } event_t;

  // step through the ring
  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
  endfunction

  // us layout make code to ascii, zero where no character
  function automatic logic [6:0] us_map(input logic [6:0] code);
    logic [6:0] c;
    c = 7'h00;
    unique case (code)
      7'd1:  c = 7'd27;
      7'd2:  c = 7'h31;
      7'd3:  c = 7'h32;
      7'd4:  c = 7'h33;
      7'd5:  c = 7'h34;
      7'd6:  c = 7'h35;
      7'd7:  c = 7'h36;
      7'd8:  c = 7'h37;
      7'd9:  c = 7'h38;
      7'd10: c = 7'h39;
      7'd11: c = 7'h30;
      7'd12: c = 7'h2D; // -
      7'd13: c = 7'h3D; // =
      7'd14: c = 7'd8;  // backspace
      7'd15: c = 7'd9;  // tab
      7'd16: c = 7'h71; // q
      7'd17: c = 7'h77; // w
      7'd18: c = 7'h65; // e
      7'd19: c = 7'h72; // r
      7'd20: c = 7'h74; // t
      7'd21: c = 7'h79; // y
      7'd22: c = 7'h75; // u
      7'd23: c = 7'h69; // i
      7'd24: c = 7'h6F; // o
      7'd25: c = 7'h70; // p
      7'd26: c = 7'h5B; // [
      7'd27: c = 7'h5D; // ]
      7'd28: c = 7'd10; // enter
      7'd30: c = 7'h61; // a
      7'd31: c = 7'h73; // s
      7'd32: c = 7'h64; // d
      7'd33: c = 7'h66; // f
      7'd34: c = 7'h67; // g
      7'd35: c = 7'h68; // h
      7'd36: c = 7'h6A; // j
      7'd37: c = 7'h6B; // k
      7'd38: c = 7'h6C; // l
      7'd39: c = 7'h3B; // ;
      7'd40: c = 7'h27; // quote
      7'd41: c = 7'h60; // backtick
      7'd43: c = 7'h5C; // backslash
      7'd44: c = 7'h7A; // z
      7'd45: c = 7'h78; // x
      7'd46: c = 7'h63; // c
      7'd47: c = 7'h76; // v
      7'd48: c = 7'h62; // b
      7'd49: c = 7'h6E; // n
      7'd50: c = 7'h6D; // m
      7'd51: c = 7'h2C; // ,
      7'd52: c = 7'h2E; // .
      7'd53: c = 7'h2F; // /
      7'd55: c = 7'h2A; // keypad *
      7'd57: c = 7'h20; // space
      default: c = 7'h00;
    endcase
    us_map = c;
  endfunction

endpackage

`default_nettype wire

### src/scancode_key_event_queue.sv
// scan-code set 1 decoder feeding a ring queue of key events, top level
//
// Each input beat is either a raw set 1 keyboard byte (in_tuser = 0) or a pop
// request (in_tuser = 1), and each gives exactly one output beat. Bytes go
// through the prefix and make-code decode and valid keys are pushed into a
// ring of QUEUE_DEPTH slots that holds at most QUEUE_DEPTH-1 events; a key
// that finds the ring full is dropped. A pop returns the oldest event with
// out_tuser = 1, or all zeros when the ring is empty. The block takes one
// beat per cycle while the output is not stalled: an input register feeds
// combinational decode and queue update into the output register, which
// loads when it is empty or being read. The head of the ring is kept in a
// registered read of the event memory, refreshed every cycle, so a pop never
// waits on the memory. No clearing pass is needed after reset.
`default_nettype none

module scancode_key_event_queue (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [skeq_pkg::IN_DATA_W-1:0]  in_tdata,  // [7:0] scan_byte
  input  wire logic                            in_tuser,  // [0] func
  // result channel
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [6:0] event_code, [7] event_pressed, [14:8] event_char, [15] queue_not_empty
  output logic [skeq_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                 out_tuser  // [0] event_valid
);
  import skeq_pkg::*;

  // input stage
  logic                 s1_valid_r, s1_valid_nxt;
  logic                 s1_func_r;
  logic [7:0]           s1_byte_r;
  logic                 in_accept;
  logic                 s1_adv;

  // queue state
  logic                 ext_pending_r, ext_pending_nxt;
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  event_t               mem [QUEUE_DEPTH];
  event_t               head_r;

  // decode
  logic [6:0]           code;
  logic                 brk;
  logic [6:0]           key_char;
  logic                 full;
  logic                 not_empty;
  logic                 push;
  logic                 pop;
  event_t               new_event;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                 out_user_r;

  // handshake
  always_comb begin
    s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
    in_tready = !s1_valid_r || s1_adv;
    in_accept = in_tvalid && in_tready;
  end

  // input register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_func_r <= in_tuser;
      s1_byte_r <= in_tdata;
    end
  end

  // byte decode and prefix tracking
  always_comb begin
    code            = s1_byte_r[6:0];
    brk             = s1_byte_r[7];
    ext_pending_nxt = ext_pending_r;
    key_char        = 7'h00;
    if (s1_func_r == FUNC_BYTE) begin
      priority if (s1_byte_r == PREFIX_EXT) begin
        ext_pending_nxt = 1'b1;
      end else if (s1_byte_r == PREFIX_PAUSE) begin
        ext_pending_nxt = 1'b0;
      end else if (ext_pending_r) begin
        ext_pending_nxt = 1'b0;
        if (!brk) begin
          priority case (code)
            CODE_UP:    key_char = CHAR_UP;
            CODE_DOWN:  key_char = CHAR_DOWN;
            CODE_LEFT:  key_char = CHAR_LEFT;
            CODE_RIGHT: key_char = CHAR_RIGHT;
            default:    key_char = 7'h00;
          endcase
        end
      end else begin
        if (!brk) begin
          key_char = us_map(code);
        end
      end
    end
  end

  // queue control
  always_comb begin
    full          = (next_slot(wr_ptr_r) == rd_ptr_r);
    not_empty     = (wr_ptr_r != rd_ptr_r);
    push          = s1_adv && (key_char != 7'h00) && !full;
    pop           = s1_adv && (s1_func_r == FUNC_POP) && not_empty;
    wr_ptr_nxt    = push ? next_slot(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt    = pop ? next_slot(rd_ptr_r) : rd_ptr_r;
    new_event.code    = code;
    new_event.pressed = 1'b1;
    new_event.ch      = key_char;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_pending_r <= 1'b0;
      wr_ptr_r      <= '0;
      rd_ptr_r      <= '0;
    end else begin
      if (s1_adv) begin
        ext_pending_r <= ext_pending_nxt;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // event memory, head kept as registered read with write bypass
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= new_event;
    end
    if (push && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= new_event;
    end else begin
      head_r <= mem[rd_ptr_nxt];
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_user_r <= pop;
      out_data_r <= {(wr_ptr_nxt != rd_ptr_nxt), (pop ? head_r : event_t'('0))};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

### src/skeq_checker.sv
// port-level checks for the key event queue, bound to the top level
`default_nettype none

module skeq_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [skeq_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                            out_tuser
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // no event means zero event fields
  a_no_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[14:0] == 15'd0)
    else $error("event fields nonzero without event");

  // a popped event is a press with a character
  a_event_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[7] && (out_tdata[14:8] != 7'd0))
    else $error("popped event malformed");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat right after reset");

endmodule

bind scancode_key_event_queue skeq_checker u_skeq_checker (.*);

`default_nettype wire

### verif/tb.sv
// self-checking testbench for the scan-code key event queue
`default_nettype none

module tb;
  import skeq_pkg::*;

  // one output beat, unpacked into its fields
  typedef struct packed {
    logic       valid;
    logic [6:0] code;
    logic       pressed;
    logic [6:0] ch;
    logic       not_empty;
  } key_result_t;

  // one row of the directed stimulus
  typedef struct packed {
    logic        func;
    logic [7:0]  scan_b;
    bit          has_typed;
    key_result_t typed;
  } stim_row_t;

  localparam int NUM_DIRECTED = 25;
  localparam int ITEMS_PER_PHASE = 412;
  localparam int TABLE_LEN = 58;

  // set 1 make code to ascii for the us layout, zero where nothing is typed
  localparam logic [6:0] US_CHARS [0:TABLE_LEN-1] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  // directed rows: quiet results are typed in, the rest come from the predictor
  localparam stim_row_t DIRECTED_ROWS [0:NUM_DIRECTED-1] = '{
    '{FUNC_POP,  8'h00, 1'b1, '0},  // pop with nothing queued
    '{FUNC_BYTE, 8'h00, 1'b1, '0},  // lowest byte, no character
    '{FUNC_BYTE, 8'hFF, 1'b1, '0},  // highest byte, a break code
    '{FUNC_BYTE, 8'hE1, 1'b1, '0},  // pause prefix on its own
    '{FUNC_BYTE, 8'h1E, 1'b0, '0},  // a
    '{FUNC_BYTE, 8'h39, 1'b0, '0},  // space, last table entry
    '{FUNC_BYTE, 8'h3A, 1'b0, '0},  // first code past the table
    '{FUNC_BYTE, 8'h7F, 1'b0, '0},  // highest make code
    '{FUNC_BYTE, 8'h01, 1'b0, '0},  // escape
    '{FUNC_BYTE, 8'hE0, 1'b0, '0},
    '{FUNC_BYTE, 8'h48, 1'b0, '0},  // up arrow
    '{FUNC_BYTE, 8'hE0, 1'b0, '0},
    '{FUNC_BYTE, 8'hE0, 1'b0, '0},  // prefix again while armed
    '{FUNC_BYTE, 8'h50, 1'b0, '0},  // down arrow
    '{FUNC_BYTE, 8'hE0, 1'b0, '0},
    '{FUNC_BYTE, 8'h4B, 1'b0, '0},  // left arrow
    '{FUNC_BYTE, 8'hE0, 1'b0, '0},
    '{FUNC_BYTE, 8'h4D, 1'b0, '0},  // right arrow
    '{FUNC_BYTE, 8'hE0, 1'b0, '0},
    '{FUNC_BYTE, 8'h1E, 1'b0, '0},  // extended non-arrow, dropped
    '{FUNC_BYTE, 8'hE0, 1'b0, '0},
    '{FUNC_BYTE, 8'hC8, 1'b0, '0},  // extended break clears the prefix
    '{FUNC_BYTE, 8'h10, 1'b0, '0},  // plain q after that
    '{FUNC_BYTE, 8'h9E, 1'b0, '0},  // plain break, dropped
    '{FUNC_POP,  8'h00, 1'b0, '0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  // predictor state
  logic   ext_armed;
  event_t key_ring [QUEUE_DEPTH];
  int     wr_idx;
  int     rd_idx;

  // expectations and bookkeeping
  key_result_t pending_key_results [$];
  bit          row_typed;
  key_result_t row_typed_val;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          beats_sent;
  int          beats_accepted;
  int          keys_queued;
  int          events_popped;
  int          empty_pops;
  int          full_drops;
  int          mismatch_count;
  int          error_count;

  scancode_key_event_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // give up after a generous fixed time
  initial begin
    #20_000_000;
    $display("[scancode_key_event_queue] ERROR");
    $finish;
  end

  // decode one beat, update the ring and return the expected output beat
  function automatic key_result_t decode_and_queue(input logic f, input logic [7:0] b);
    key_result_t r;
    logic [6:0]  code;
    logic [6:0]  ch;
    r = '0;
    ch = '0;
    code = b[6:0];
    if (f == FUNC_BYTE) begin
      if (b == PREFIX_EXT) begin
        ext_armed = 1'b1;
      end else if (b == PREFIX_PAUSE) begin
        ext_armed = 1'b0;
      end else if (ext_armed) begin
        ext_armed = 1'b0;
        if (!b[7]) begin
          case (code)
            CODE_UP:    ch = CHAR_UP;
            CODE_DOWN:  ch = CHAR_DOWN;
            CODE_LEFT:  ch = CHAR_LEFT;
            CODE_RIGHT: ch = CHAR_RIGHT;
            default:    ch = '0;
          endcase
        end
      end else if (!b[7] && code < TABLE_LEN) begin
        ch = US_CHARS[code];
      end
      // push unless the ring is full
      if (ch != '0) begin
        if ((wr_idx + 1) % QUEUE_DEPTH != rd_idx) begin
          key_ring[wr_idx].code = code;
          key_ring[wr_idx].pressed = 1'b1;
          key_ring[wr_idx].ch = ch;
          wr_idx = (wr_idx + 1) % QUEUE_DEPTH;
          keys_queued++;
        end else begin
          full_drops++;
        end
      end
    end else if (wr_idx != rd_idx) begin
      r.valid = 1'b1;
      r.code = key_ring[rd_idx].code;
      r.pressed = key_ring[rd_idx].pressed;
      r.ch = key_ring[rd_idx].ch;
      rd_idx = (rd_idx + 1) % QUEUE_DEPTH;
      events_popped++;
    end else begin
      empty_pops++;
    end
    r.not_empty = (wr_idx != rd_idx);
    return r;
  endfunction

  // result side stalls
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // predict on every accepted input beat, check every accepted output beat
  always @(posedge clk) begin
    key_result_t want;
    key_result_t got;
    bit          bad;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        want = decode_and_queue(in_tuser, in_tdata);
        if (row_typed) want = row_typed_val;
        pending_key_results.push_back(want);
        beats_accepted++;
      end
      if (out_tvalid && out_tready) begin
        got.valid = out_tuser;
        got.code = out_tdata[6:0];
        got.pressed = out_tdata[7];
        got.ch = out_tdata[14:8];
        got.not_empty = out_tdata[15];
        if (pending_key_results.size() == 0) begin
          error_count++;
          $display("output beat with nothing expected: tuser=%b tdata=%h",
                   out_tuser, out_tdata);
        end else begin
          want = pending_key_results.pop_front();
          bad = (got.valid !== want.valid) || (got.code !== want.code) ||
                (got.pressed !== want.pressed) || (got.ch !== want.ch) ||
                (got.not_empty !== want.not_empty);
          if (bad) begin
            mismatch_count++;
            error_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch: exp valid=%b code=%h pressed=%b char=%h not_empty=%b",
                       want.valid, want.code, want.pressed, want.ch, want.not_empty);
              $display("          got valid=%b code=%h pressed=%b char=%h not_empty=%b",
                       got.valid, got.code, got.pressed, got.ch, got.not_empty);
            end
          end
        end
      end
    end
  end

  // drive one input beat from a falling edge and hold it until accepted
  task automatic send_beat(input logic f, input logic [7:0] b,
                           input bit typed = 1'b0, input key_result_t tv = '0);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= f;
    in_tdata <= b;
    row_typed = typed;
    row_typed_val = tv;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
  endtask

  // one keystroke (plain or arrow, sometimes followed by its release) or a prefix with a random byte
  task automatic send_keystroke();
    int         sel;
    logic [6:0] code;
    sel = $urandom_range(0, 99);
    if (sel < 65) begin
      code = 7'($urandom_range(1, TABLE_LEN - 1));
      send_beat(FUNC_BYTE, {1'b0, code});
      if ($urandom_range(0, 2) == 0) send_beat(FUNC_BYTE, {1'b1, code});
    end else if (sel < 85) begin
      case ($urandom_range(0, 3))
        0:       code = CODE_UP;
        1:       code = CODE_DOWN;
        2:       code = CODE_LEFT;
        default: code = CODE_RIGHT;
      endcase
      send_beat(FUNC_BYTE, PREFIX_EXT);
      send_beat(FUNC_BYTE, {1'b0, code});
      if ($urandom_range(0, 2) == 0) begin
        send_beat(FUNC_BYTE, PREFIX_EXT);
        send_beat(FUNC_BYTE, {1'b1, code});
      end
    end else if (sel < 95) begin
      send_beat(FUNC_BYTE, PREFIX_EXT);
      send_beat(FUNC_BYTE, 8'($urandom_range(0, 255)));
    end else begin
      send_beat(FUNC_BYTE, PREFIX_PAUSE);
      send_beat(FUNC_BYTE, 8'($urandom_range(0, 127)));
    end
  endtask

  // random traffic: typing bursts, pop bursts and raw noise
  task automatic run_random(input int n_items);
    int target;
    int n;
    int kind;
    target = beats_sent + n_items;
    while (beats_sent < target) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        n = $urandom_range(1, 40);
        repeat (n) send_keystroke();
      end else if (kind < 8) begin
        n = $urandom_range(1, 40);
        repeat (n) send_beat(FUNC_POP, 8'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // main sequence
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = FUNC_BYTE;
    out_tready = 1'b0;
    row_typed = 1'b0;
    row_typed_val = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    beats_sent = 0;
    beats_accepted = 0;
    keys_queued = 0;
    events_popped = 0;
    empty_pops = 0;
    full_drops = 0;
    mismatch_count = 0;
    error_count = 0;
    ext_armed = 1'b0;
    wr_idx = 0;
    rd_idx = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed rows, no idling
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_beat(DIRECTED_ROWS[i].func, DIRECTED_ROWS[i].scan_b,
                DIRECTED_ROWS[i].has_typed, DIRECTED_ROWS[i].typed);
    end

    // random traffic through the idling phases
    run_random(ITEMS_PER_PHASE);
    send_idle_pct = 74;
    run_random(ITEMS_PER_PHASE);
    send_idle_pct = 0;
    recv_stall_pct = 74;
    run_random(ITEMS_PER_PHASE);
    send_idle_pct = 12;
    recv_stall_pct = 12;
    run_random(ITEMS_PER_PHASE);

    // drain and let the pipeline settle
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_key_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_key_results.size() != 0) error_count++;

    $display("ran %0d beats: %0d keys queued, %0d events popped, %0d empty pops",
             beats_accepted, keys_queued, events_popped, empty_pops);
    $display("%0d keys dropped on a full ring, %0d field mismatches",
             full_drops, mismatch_count);
    if (error_count == 0) begin
      $display("[scancode_key_event_queue] OK");
    end else begin
      $display("[scancode_key_event_queue] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
